@@ hw/rtl/sweep_prune_circle_pairs_defines.svh @@
// Assertion macros shared by the sweep and prune circle pair finder.
// Depends on nothing; included by modules that carry assertions.
`ifndef SWEEP_PRUNE_CIRCLE_PAIRS_DEFINES_SVH
`define SWEEP_PRUNE_CIRCLE_PAIRS_DEFINES_SVH
// Checks a property at every rising clock edge outside reset.
`define SPCP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checks that a condition implies a consequence in the next cycle.
`define SPCP_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);
`endif

@@ hw/rtl/spcp_pkg.sv @@
// Shared types and constants of the sweep and prune circle pair finder.
// Depends on nothing.
package spcp_pkg;
   localparam int COORD_BITS  = 16;
   localparam int RADIUS_BITS = 12;
   localparam int EDGE_BITS   = 18;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]  x;
      logic signed [COORD_BITS-1:0]  y;
      logic        [RADIUS_BITS-1:0] r;
   } geo_type;

   localparam int GEO_BITS = $bits(geo_type);
   localparam logic signed [EDGE_BITS-1:0] EDGE_MIN = {1'b1, {(EDGE_BITS-1){1'b0}}};
endpackage

@@ hw/rtl/spcp_ram.sv @@
// Active set memory: one write port, one read port with registered data.
// Depends on nothing.
module spcp_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 54
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

@@ hw/rtl/spcp_col.sv @@
// Overlap test of two circles: registered squares, then sum and compare.
// Depends on spcp_pkg.
module spcp_col import spcp_pkg::*; (
   input  logic    clock,
   input  logic    en,
   input  geo_type cur,
   input  geo_type ent,
   output logic    hit
);
   logic signed [COORD_BITS:0]  dx, dy;
   logic signed [2*COORD_BITS+1:0] px, py;
   logic [RADIUS_BITS:0]        rs;
   logic [2*COORD_BITS-1:0]     dx2_ff, dy2_ff;
   logic [2*RADIUS_BITS+1:0]    rs2_ff;
   logic [2*COORD_BITS:0]       dist2;

   assign dx = (COORD_BITS+1)'(cur.x) - (COORD_BITS+1)'(ent.x);
   assign dy = (COORD_BITS+1)'(cur.y) - (COORD_BITS+1)'(ent.y);
   assign px = dx * dx;
   assign py = dy * dy;
   assign rs = {1'b0, cur.r} + {1'b0, ent.r};

   always_ff @(posedge clock) begin
      if (en) begin
         dx2_ff <= px[2*COORD_BITS-1:0];
         dy2_ff <= py[2*COORD_BITS-1:0];
         rs2_ff <= rs * rs;
      end
   end

   assign dist2 = {1'b0, dx2_ff} + {1'b0, dy2_ff};
   assign hit = dist2 < (2*COORD_BITS+1)'(rs2_ff);
endmodule

@@ hw/rtl/sweep_prune_circle_pairs.sv @@
// Sweep and prune circle pair finder, top level.
// Depends on spcp_pkg, spcp_ram, spcp_col and the assertion macro header.
// Each request is accepted in IDLE; each stored circle is then read in EVAL,
// through the single read port of the active set memory. A stored circle that
// is dropped is handled in EVAL alone; one that stays is squared in EVAL, then
// compared and reported in COMP. FINISH issues the final marker. A hit in COMP
// and the marker in FINISH wait while rsp_stall holds a result.
`include "sweep_prune_circle_pairs_defines.svh"
module sweep_prune_circle_pairs import spcp_pkg::*; #(
   parameter int ACTIVE_DEPTH = 32,
   parameter int ID_BITS      = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_frame_start,
   input  logic [ID_BITS-1:0]        req_object_id,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic [RADIUS_BITS-1:0]    req_radius,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [ID_BITS-1:0]        rsp_first_id,
   output logic [ID_BITS-1:0]        rsp_second_id,
   output logic                      rsp_is_pair,
   output logic                      rsp_last,
   output logic                      rsp_overflow,
   output logic                      rsp_order_error
);
   localparam int AW    = $clog2(ACTIVE_DEPTH);
   localparam int CW    = $clog2(ACTIVE_DEPTH + 1);
   localparam int EW    = ID_BITS + GEO_BITS;
   localparam logic [CW-1:0] FULL = CW'(ACTIVE_DEPTH);

   typedef enum logic [1:0] {IDLE, EVAL, COMP, FINISH} state_type;

   state_type state_ff, state_in;
   logic [ID_BITS-1:0] cur_id_ff, cur_id_in, pair_id_ff, pair_id_in;
   geo_type cur_geo_ff, cur_geo_in;
   logic order_ff, order_in;
   logic [CW-1:0] cnt_ff, cnt_in, idx_ff, idx_in, kept_ff, kept_in;
   logic signed [EDGE_BITS-1:0] prev_ff, prev_in, left_ff, left_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [ID_BITS-1:0] rsp_first_ff, rsp_first_in, rsp_second_ff, rsp_second_in;
   logic rsp_pair_ff, rsp_pair_in, rsp_last_ff, rsp_last_in;
   logic rsp_ovf_ff, rsp_ovf_in, rsp_ord_ff, rsp_ord_in;

   logic we, col_en, hit, keep, out_free, accept;
   logic [AW-1:0] waddr, raddr;
   logic [EW-1:0] wdata, rdata;
   geo_type ent_geo, req_geo;
   logic [ID_BITS-1:0] ent_id;
   logic signed [EDGE_BITS-1:0] req_left, ent_right, eff_prev;
   logic [CW-1:0] eff_cnt, idx_next;

   spcp_ram #(.DEPTH(ACTIVE_DEPTH), .WIDTH(EW)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   spcp_col u_col (
      .clock(clock), .en(col_en), .cur(cur_geo_ff), .ent(ent_geo), .hit(hit)
   );

   assign req_geo   = '{x: req_pos_x, y: req_pos_y, r: req_radius};
   assign ent_id    = rdata[EW-1:GEO_BITS];
   assign ent_geo   = geo_type'(rdata[GEO_BITS-1:0]);
   assign req_left  = EDGE_BITS'(req_pos_x) - EDGE_BITS'({1'b0, req_radius});
   assign ent_right = EDGE_BITS'(ent_geo.x) + EDGE_BITS'({1'b0, ent_geo.r});
   assign keep      = ent_right >= left_ff;
   assign eff_cnt   = req_frame_start ? '0 : cnt_ff;
   assign eff_prev  = req_frame_start ? EDGE_MIN : prev_ff;
   assign idx_next  = idx_ff + CW'(1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != IDLE;
   assign accept    = req_valid && !req_stall;
   assign col_en    = state_ff == EVAL;

   always_comb begin
      we    = 1'b0;
      waddr = kept_ff[AW-1:0];
      wdata = rdata;
      raddr = idx_ff[AW-1:0];
      if (state_ff == IDLE) begin
         raddr = '0;
      end else if (state_ff == EVAL) begin
         we    = keep;
         raddr = idx_next[AW-1:0];
      end else if (state_ff == FINISH) begin
         we    = out_free && kept_ff != FULL;
         wdata = {cur_id_ff, cur_geo_ff};
      end
   end

   always_comb begin
      state_in      = state_ff;
      cur_id_in     = cur_id_ff;
      cur_geo_in    = cur_geo_ff;
      pair_id_in    = pair_id_ff;
      order_in      = order_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      kept_in       = kept_ff;
      prev_in       = prev_ff;
      left_in       = left_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_pair_in   = rsp_pair_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_ord_in    = rsp_ord_ff;
      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               cur_id_in  = req_object_id;
               cur_geo_in = req_geo;
               left_in    = req_left;
               prev_in    = req_left;
               order_in   = req_left < eff_prev;
               cnt_in     = eff_cnt;
               idx_in     = '0;
               kept_in    = '0;
               state_in   = (eff_cnt != '0) ? EVAL : FINISH;
            end
         end
         EVAL: begin
            idx_in     = idx_next;
            pair_id_in = ent_id;
            if (keep) begin
               kept_in  = kept_ff + CW'(1);
               state_in = COMP;
            end else begin
               state_in = (idx_next < cnt_ff) ? EVAL : FINISH;
            end
         end
         COMP: begin
            if (!hit || out_free) begin
               state_in = (idx_ff < cnt_ff) ? EVAL : FINISH;
            end
            if (hit && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_first_in  = cur_id_ff;
               rsp_second_in = pair_id_ff;
               rsp_pair_in   = 1'b1;
               rsp_last_in   = 1'b0;
               rsp_ovf_in    = 1'b0;
               rsp_ord_in    = 1'b0;
            end
         end
         FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_first_in  = cur_id_ff;
               rsp_second_in = '0;
               rsp_pair_in   = 1'b0;
               rsp_last_in   = 1'b1;
               rsp_ovf_in    = kept_ff == FULL;
               rsp_ord_in    = order_ff;
               cnt_in        = (kept_ff == FULL) ? kept_ff : kept_ff + CW'(1);
               state_in      = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         kept_ff      <= '0;
         prev_ff      <= EDGE_MIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         kept_ff      <= kept_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_id_ff     <= cur_id_in;
      cur_geo_ff    <= cur_geo_in;
      pair_id_ff    <= pair_id_in;
      order_ff      <= order_in;
      left_ff       <= left_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_pair_ff   <= rsp_pair_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_ord_ff    <= rsp_ord_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_first_id    = rsp_first_ff;
   assign rsp_second_id   = rsp_second_ff;
   assign rsp_is_pair     = rsp_pair_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_overflow    = rsp_ovf_ff;
   assign rsp_order_error = rsp_ord_ff;

   `SPCP_ASSERT(a_cnt_bound, cnt_ff <= FULL, "active count exceeds depth")
   `SPCP_ASSERT(a_kept_behind, kept_ff <= idx_ff, "compaction write passed the read index")
   `SPCP_ASSERT(a_marker_shape, !(rsp_valid_ff && rsp_pair_ff && rsp_last_ff),
      "pair result marked as last")
   `SPCP_ASSERT_NEXT(a_finish_idle, state_ff == FINISH && out_free, state_ff == IDLE,
      "marker issued without returning to idle")
endmodule
